// ===== design/owtr_pkg.sv =====
// owtr_pkg: shared types, phase codes and timing constants for the
// one-wire temperature read sequencer. No dependencies.
`timescale 1ns / 1ps

package owtr_pkg;

    localparam int TIMER_BITS = 20;
    localparam int PHASE_W    = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [TIMER_BITS-1:0] RECOVERY_TICKS    = TIMER_BITS'(5);
    localparam logic [TIMER_BITS-1:0] WRITE1_HIGH_TICKS = TIMER_BITS'(54);
    localparam logic [TIMER_BITS-1:0] READ_TAIL_TICKS   = TIMER_BITS'(45);

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RST_LOW   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RST_WAIT  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PRES_TAIL = 4'd3;
    localparam logic [PHASE_W-1:0] PH_W_LOW     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_W_HIGH    = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CONV      = 4'd6;
    localparam logic [PHASE_W-1:0] PH_R_LOW     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_R_WAIT    = 4'd8;
    localparam logic [PHASE_W-1:0] PH_R_TAIL    = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_TAIL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE0_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE1_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_WAIT  = 3'd7;

    // bus commands
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRAT = 8'hBE;

    typedef struct packed {
        logic [TIMER_BITS-1:0] reset_low_ticks;
        logic [TIMER_BITS-1:0] reset_release_ticks;
        logic [TIMER_BITS-1:0] presence_tail_ticks;
        logic [TIMER_BITS-1:0] write0_low_ticks;
        logic [TIMER_BITS-1:0] write1_low_ticks;
        logic [TIMER_BITS-1:0] read_low_ticks;
        logic [TIMER_BITS-1:0] read_sample_ticks;
        logic [TIMER_BITS-1:0] convert_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        present;
        logic [15:0] temperature_raw;
    } res_t;

    // bit of the command byte sent in the given command slot
    function automatic logic cmd_bit(input logic [1:0] cmd_idx, input logic [2:0] bit_idx);
        logic [7:0] b;
        begin
            case (cmd_idx)
                2'd0:    b = CMD_SKIP_ROM;
                2'd1:    b = CMD_CONVERT;
                2'd2:    b = CMD_SKIP_ROM;
                default: b = CMD_READ_SCRAT;
            endcase
            cmd_bit = b[bit_idx];
        end
    endfunction

endpackage

// ===== design/onewire_temperature_read_sequencer_top.sv =====
// onewire_temperature_read_sequencer_top: request channels, config registers
// and the output register around the sequencer. Depends on owtr_pkg, owtr_core.
`timescale 1ns / 1ps

// One request is one bus tick (action 0, with the sampled line level) or a
// start (action 1). Every request gives exactly one result showing drive
// level, busy, the last presence sample, a done pulse and the last raw
// temperature word. Requests flow at one per clock while the output side
// keeps up: a request is held in an input register, stepped combinationally
// through the sequencer, and its result lands in an output register. Timing
// registers are written through cfg_we/cfg_index/cfg_wdata and should be
// changed only while no read is running.

module onewire_temperature_read_sequencer_top
    import owtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic                  line_level,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  drive_low,
    output logic                  busy_res,
    output logic                  done_res,
    output logic                  present,
    output logic [15:0]           temperature_raw,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIMER_BITS-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic in_valid_reg;
    logic action_reg;
    logic line_reg;
    logic out_valid_reg;
    res_t res_reg;
    res_t res_core;
    logic out_free;
    logic step_en;

    assign out_free = !out_valid_reg || out_ready;
    assign step_en  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= TIMER_BITS'(480);
            cfg_reg.reset_release_ticks <= TIMER_BITS'(70);
            cfg_reg.presence_tail_ticks <= TIMER_BITS'(415);
            cfg_reg.write0_low_ticks    <= TIMER_BITS'(60);
            cfg_reg.write1_low_ticks    <= TIMER_BITS'(6);
            cfg_reg.read_low_ticks      <= TIMER_BITS'(6);
            cfg_reg.read_sample_ticks   <= TIMER_BITS'(9);
            cfg_reg.convert_wait_ticks  <= TIMER_BITS'(750010);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESET_LOW:     cfg_reg.reset_low_ticks     <= cfg_wdata;
                CFG_RESET_RELEASE: cfg_reg.reset_release_ticks <= cfg_wdata;
                CFG_PRESENCE_TAIL: cfg_reg.presence_tail_ticks <= cfg_wdata;
                CFG_WRITE0_LOW:    cfg_reg.write0_low_ticks    <= cfg_wdata;
                CFG_WRITE1_LOW:    cfg_reg.write1_low_ticks    <= cfg_wdata;
                CFG_READ_LOW:      cfg_reg.read_low_ticks      <= cfg_wdata;
                CFG_READ_SAMPLE:   cfg_reg.read_sample_ticks   <= cfg_wdata;
                CFG_CONVERT_WAIT:  cfg_reg.convert_wait_ticks  <= cfg_wdata;
                default:           cfg_reg.reset_low_ticks     <= cfg_reg.reset_low_ticks;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            line_reg   <= line_level;
        end
        if (step_en)
            res_reg <= res_core;
    end

    owtr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .action     (action_reg),
        .line_level (line_reg),
        .cfg        (cfg_reg),
        .res        (res_core)
    );

    assign out_valid       = out_valid_reg;
    assign drive_low       = res_reg.drive_low;
    assign busy_res        = res_reg.busy;
    assign done_res        = res_reg.done;
    assign present         = res_reg.present;
    assign temperature_raw = res_reg.temperature_raw;

endmodule

// ===== design/owtr_core.sv =====
// owtr_core: bus phase sequencer, one tick or start request per step.
// Depends on owtr_pkg.
`timescale 1ns / 1ps

module owtr_core
    import owtr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  logic action,
    input  logic line_level,
    input  cfg_t cfg,
    output res_t res
);

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [2:0]            bit_idx_reg, bit_idx_next;
    logic [3:0]            byte_idx_reg, byte_idx_next;
    logic [1:0]            cmd_idx_reg, cmd_idx_next;
    logic [15:0]           shift_reg, shift_next;
    logic                  present_reg, present_next;
    logic [15:0]           result_reg, result_next;
    logic                  done_next;

    logic [TIMER_BITS-1:0] dur;
    logic [TIMER_BITS-1:0] dur_eff;
    logic                  last_tick;
    logic                  bit_now;

    assign bit_now = cmd_bit(cmd_idx_reg, bit_idx_reg);

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:   dur = cfg.reset_low_ticks;
            PH_RST_WAIT:  dur = cfg.reset_release_ticks;
            PH_PRES_TAIL: dur = cfg.presence_tail_ticks;
            PH_W_LOW:     dur = bit_now ? cfg.write1_low_ticks : cfg.write0_low_ticks;
            PH_W_HIGH:    dur = bit_now ? (WRITE1_HIGH_TICKS + RECOVERY_TICKS) : RECOVERY_TICKS;
            PH_CONV:      dur = cfg.convert_wait_ticks;
            PH_R_LOW:     dur = cfg.read_low_ticks;
            PH_R_WAIT:    dur = cfg.read_sample_ticks;
            PH_R_TAIL:    dur = READ_TAIL_TICKS + RECOVERY_TICKS;
            default:      dur = TIMER_BITS'(1);
        endcase
    end

    // zero duration counts as one tick
    assign dur_eff   = (dur == '0) ? TIMER_BITS'(1) : dur;
    assign last_tick = ({1'b0, tick_reg} + (TIMER_BITS+1)'(1)) >= {1'b0, dur_eff};

    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        cmd_idx_next  = cmd_idx_reg;
        shift_next    = shift_reg;
        present_next  = present_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        if (action)
        begin
            if (phase_reg == PH_IDLE)
            begin
                phase_next    = PH_RST_LOW;
                tick_next     = '0;
                bit_idx_next  = '0;
                byte_idx_next = '0;
                cmd_idx_next  = '0;
                shift_next    = '0;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (phase_reg == PH_PRES_TAIL && tick_reg == '0)
                present_next = line_level;
            // only the first two scratchpad bytes are kept
            if (phase_reg == PH_R_TAIL && tick_reg == '0 && byte_idx_reg < 4'd2 && line_level)
                shift_next[{byte_idx_reg[0], bit_idx_reg}] = 1'b1;
            if (!last_tick)
                tick_next = tick_reg + TIMER_BITS'(1);
            else
            begin
                tick_next = '0;
                unique case (phase_reg)
                    PH_RST_LOW:   phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:  phase_next = PH_PRES_TAIL;
                    PH_PRES_TAIL:
                    begin
                        bit_idx_next = '0;
                        phase_next   = PH_W_LOW;
                    end
                    PH_W_LOW:     phase_next = PH_W_HIGH;
                    PH_W_HIGH:
                    begin
                        if (bit_idx_reg != 3'd7)
                        begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                            phase_next   = PH_W_LOW;
                        end
                        else
                        begin
                            bit_idx_next = '0;
                            if (cmd_idx_reg == 2'd1)
                            begin
                                cmd_idx_next = 2'd2;
                                phase_next   = PH_CONV;
                            end
                            else if (cmd_idx_reg == 2'd3)
                            begin
                                byte_idx_next = '0;
                                phase_next    = PH_R_LOW;
                            end
                            else
                            begin
                                cmd_idx_next = cmd_idx_reg + 2'd1;
                                phase_next   = PH_W_LOW;
                            end
                        end
                    end
                    PH_CONV:      phase_next = PH_RST_LOW;
                    PH_R_LOW:     phase_next = PH_R_WAIT;
                    PH_R_WAIT:    phase_next = PH_R_TAIL;
                    PH_R_TAIL:
                    begin
                        if (bit_idx_reg != 3'd7)
                        begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                            phase_next   = PH_R_LOW;
                        end
                        else
                        begin
                            bit_idx_next = '0;
                            if (byte_idx_reg < 4'd8)
                            begin
                                byte_idx_next = byte_idx_reg + 4'd1;
                                phase_next    = PH_R_LOW;
                            end
                            else
                            begin
                                result_next = shift_next;
                                phase_next  = PH_IDLE;
                                done_next   = 1'b1;
                            end
                        end
                    end
                    default:      phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_idx_reg  <= '0;
            byte_idx_reg <= '0;
            cmd_idx_reg  <= '0;
            shift_reg    <= '0;
            present_reg  <= 1'b0;
            result_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
            cmd_idx_reg  <= cmd_idx_next;
            shift_reg    <= shift_next;
            present_reg  <= present_next;
            result_reg   <= result_next;
        end
    end

    assign res.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW)
                           || (phase_next == PH_R_LOW);
    assign res.busy            = (phase_next != PH_IDLE);
    assign res.done            = done_next;
    assign res.present         = present_next;
    assign res.temperature_raw = result_next;

endmodule

// ===== design/owtr_checker.sv =====
// owtr_checker: port-level checks on the sequencer top, attached by bind.
// Depends on owtr_pkg and onewire_temperature_read_sequencer_top.
`timescale 1ns / 1ps

module owtr_checker
    import owtr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        drive_low,
    input logic        busy_res,
    input logic        done_res,
    input logic        present,
    input logic [15:0] temperature_raw
);

    // completing a read returns the sequencer to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done shown while still busy");

    // the bus is only pulled low during a running read
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_low |-> busy_res)
        else $error("bus driven low while idle");

    // the request after a completion cannot complete again
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && done_res |=> !(out_valid && done_res))
        else $error("two completions in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_low) && $stable(busy_res)
            && $stable(done_res) && $stable(present) && $stable(temperature_raw))
        else $error("stalled result changed");

endmodule

bind onewire_temperature_read_sequencer_top owtr_checker u_owtr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .drive_low       (drive_low),
    .busy_res        (busy_res),
    .done_res        (done_res),
    .present         (present),
    .temperature_raw (temperature_raw)
);
